@@ hdl/gjk_pkg.sv @@
// ----------------------------------------------------------------------------
// gjk_pkg
// Shared widths, vector types, status codes and sequencer states for the
// GJK simplex refinement core.
// ----------------------------------------------------------------------------
package gjk_pkg;

    // coordinate and arithmetic widths
    localparam int PT_W  = 16;   // support point coordinate
    localparam int DF_W  = 17;   // point difference / negated point
    localparam int N_W   = 35;   // cross product of two differences
    localparam int WD_W  = 53;   // wide operand, direction
    localparam int PR_W  = 70;   // product of wide and narrow operand
    localparam int AC_W  = 72;   // accumulator of three products
    localparam int CNT_W = 3;    // simplex size and step counter

    localparam int COORD_BITS_DEF = 16;

    // query status as reported on the result beat
    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_SEP  = 2'd1,
        ST_HIT  = 2'd2
    } t_status;

    // sequencer states: each compute state runs one dot or cross product
    typedef enum logic [3:0] {
        S_IDLE,
        S_DOTP,   // dot(point, dir)
        S_LD,     // line: dot(ab, ao)
        S_LC1,    // line: t = x cross ao
        S_LC2,    // line: dir = t cross x
        S_RN,     // triangle: n = ab cross ac
        S_RT,     // triangle: t = n cross ac
        S_RD1,    // triangle: dot(t, ao)
        S_RD2,    // triangle: dot(ac, ao)
        S_RU,     // triangle: t = ab cross n
        S_RD3,    // triangle: dot(t, ao)
        S_RD4,    // triangle: dot(n, ao)
        S_TC,     // tetra: t = face normal
        S_TD,     // tetra: dot(t, ao)
        S_WB      // write result beat
    } t_state;

    typedef logic signed [PT_W-1:0] t_pt [3];
    typedef logic signed [DF_W-1:0] t_df [3];
    typedef logic signed [N_W-1:0]  t_nv [3];
    typedef logic signed [WD_W-1:0] t_wv [3];

endpackage

@@ hdl/gjk_simplex_refine_step.sv @@
// ----------------------------------------------------------------------------
// gjk_simplex_refine_step
// Per-point core of a 3-D GJK intersection test on integer coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one support point per beat plus
//   a start flag. Output channel (o_valid / i_ready) returns one result beat
//   per input beat: next search direction, status and simplex point count.
//   A start beat, or any beat before the first query, seeds a one-point
//   simplex. After a separated or intersecting result, non-start beats repeat
//   the stored result without changing state.
//   Start and finished-query beats go straight to the write-back state; other
//   beats run a dot product against the direction and write back on a
//   separation, else refine the simplex, where a tetrahedron may fall back to a
//   triangle and then a line. Every dot and cross product runs on the one
//   shared 53x17 multiplier with its accumulator; a new point is taken only
//   when the sequencer is idle.
//   The result sits in an output register, so the sequencer goes back to idle
//   and takes the next point while the result waits; it then holds in its
//   write-back state until the receiver takes the previous beat.
//   Reset (synchronous, active low) clears the simplex size, the status and
//   the output valid; the block is ready the cycle after reset drops.
// ----------------------------------------------------------------------------
module gjk_simplex_refine_step #(
    parameter int COORD_BITS = gjk_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_start_req,
    input  logic signed [gjk_pkg::PT_W-1:0] i_point_x,
    input  logic signed [gjk_pkg::PT_W-1:0] i_point_y,
    input  logic signed [gjk_pkg::PT_W-1:0] i_point_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [gjk_pkg::WD_W-1:0] o_dir_x,
    output logic signed [gjk_pkg::WD_W-1:0] o_dir_y,
    output logic signed [gjk_pkg::WD_W-1:0] o_dir_z,
    output logic [1:0]                      o_status,
    output logic [gjk_pkg::CNT_W-1:0]       o_point_count
);

    localparam int PT_W  = gjk_pkg::PT_W;
    localparam int DF_W  = gjk_pkg::DF_W;
    localparam int N_W   = gjk_pkg::N_W;
    localparam int WD_W  = gjk_pkg::WD_W;
    localparam int PR_W  = gjk_pkg::PR_W;
    localparam int AC_W  = gjk_pkg::AC_W;
    localparam int CNT_W = gjk_pkg::CNT_W;
    localparam int SH    = PT_W - COORD_BITS;

    // sequencer
    gjk_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;

    // working points and query state
    gjk_pkg::t_pt     r_a, r_b, r_c, r_d;
    gjk_pkg::t_pt     r_s0, r_s1, r_s2;
    logic [CNT_W-1:0] r_size;
    gjk_pkg::t_status r_fin;
    gjk_pkg::t_wv     r_dir;
    gjk_pkg::t_nv     r_n;
    gjk_pkg::t_wv     r_t;
    logic             r_lsel;
    logic [1:0]       r_face;

    // shared multiply-accumulate
    logic signed [PR_W-1:0] r_prod;
    logic signed [AC_W-1:0] r_acc, acc_n, prod_x;

    // output register
    logic                   r_o_valid;
    gjk_pkg::t_wv           r_o_dir;
    gjk_pkg::t_status       r_o_stat;
    logic [CNT_W-1:0]       r_o_cnt;

    gjk_pkg::t_pt p_in;
    gjk_pkg::t_df ab, ac, ad, ao, xv;
    gjk_pkg::t_wv wv;
    gjk_pkg::t_df sv;
    logic signed [WD_W-1:0] w_sel;
    logic signed [DF_W-1:0] s_sel;

    logic             accept, is_cross, swap, last, pos, op_load, op_sub, wb_fire;
    logic [CNT_W-1:0] len, j;
    logic [1:0]       c, i1, i2, wi, si;
    logic             ph;
    logic             set_start, set_sep, set_s1, set_s2, set_s3, set_s4, remap;

    // sign-extend the used coordinate bits
    always_comb begin
        p_in[0] = (i_point_x <<< SH) >>> SH;
        p_in[1] = (i_point_y <<< SH) >>> SH;
        p_in[2] = (i_point_z <<< SH) >>> SH;
    end

    // edge vectors from the working points
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ab[i] = DF_W'(r_b[i]) - DF_W'(r_a[i]);
            ac[i] = DF_W'(r_c[i]) - DF_W'(r_a[i]);
            ad[i] = DF_W'(r_d[i]) - DF_W'(r_a[i]);
            ao[i] = -DF_W'(r_a[i]);
            xv[i] = r_lsel ? ac[i] : ab[i];
        end
    end

    // pick the operand vectors for the current step
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wv[i] = r_dir[i];
            sv[i] = ao[i];
            unique case (r_state)
                gjk_pkg::S_DOTP: begin
                    wv[i] = r_dir[i];
                    sv[i] = DF_W'(r_a[i]);
                end
                gjk_pkg::S_LD:  wv[i] = WD_W'(ab[i]);
                gjk_pkg::S_LC1: wv[i] = WD_W'(xv[i]);
                gjk_pkg::S_LC2: begin
                    wv[i] = r_t[i];
                    sv[i] = xv[i];
                end
                gjk_pkg::S_RN: begin
                    wv[i] = WD_W'(ab[i]);
                    sv[i] = ac[i];
                end
                gjk_pkg::S_RT: begin
                    wv[i] = WD_W'(r_n[i]);
                    sv[i] = ac[i];
                end
                gjk_pkg::S_RD1, gjk_pkg::S_RD3, gjk_pkg::S_TD: wv[i] = r_t[i];
                gjk_pkg::S_RD2: wv[i] = WD_W'(ac[i]);
                gjk_pkg::S_RU: begin
                    wv[i] = WD_W'(r_n[i]);
                    sv[i] = ab[i];
                end
                gjk_pkg::S_RD4: wv[i] = WD_W'(r_n[i]);
                gjk_pkg::S_TC: begin
                    priority if (r_face == 2'd0) begin
                        wv[i] = WD_W'(ab[i]);
                        sv[i] = ac[i];
                    end else if (r_face == 2'd1) begin
                        wv[i] = WD_W'(ac[i]);
                        sv[i] = ad[i];
                    end else begin
                        wv[i] = WD_W'(ad[i]);
                        sv[i] = ab[i];
                    end
                end
                default: ;
            endcase
        end
    end

    // step decode: component indexes, accumulate op, end of operation
    always_comb begin
        is_cross = (r_state == gjk_pkg::S_LC1) || (r_state == gjk_pkg::S_LC2) ||
                   (r_state == gjk_pkg::S_RN)  || (r_state == gjk_pkg::S_RT)  ||
                   (r_state == gjk_pkg::S_RU)  || (r_state == gjk_pkg::S_TC);
        swap     = (r_state == gjk_pkg::S_RU);
        len      = is_cross ? CNT_W'(6) : CNT_W'(3);
        last     = (r_k == len);
        j        = r_k - CNT_W'(1);
        c        = r_k[2:1];
        ph       = r_k[0] ^ swap;
        i1       = (c == 2'd2) ? 2'd0 : c + 2'd1;
        i2       = (c == 2'd0) ? 2'd2 : c - 2'd1;
        wi       = is_cross ? (ph ? i2 : i1) : r_k[1:0];
        si       = is_cross ? (ph ? i1 : i2) : r_k[1:0];
        w_sel    = (wi == 2'd2) ? wv[2] : (wi == 2'd1) ? wv[1] : wv[0];
        s_sel    = (si == 2'd2) ? sv[2] : (si == 2'd1) ? sv[1] : sv[0];
        op_load  = is_cross ? !j[0] : (j == '0);
        op_sub   = is_cross && j[0];
        prod_x   = AC_W'(r_prod);
        priority if (op_load) acc_n = prod_x;
        else if (op_sub)      acc_n = r_acc - prod_x;
        else                  acc_n = r_acc + prod_x;
        pos      = !acc_n[AC_W-1] && (acc_n != '0);
    end

    // result events
    always_comb begin
        accept    = i_valid && (r_state == gjk_pkg::S_IDLE);
        set_start = accept && (i_start_req || (r_size == '0));
        set_sep   = (r_state == gjk_pkg::S_DOTP) && last && !pos;
        set_s1    = (r_state == gjk_pkg::S_LD) && last && !pos;
        set_s2    = (r_state == gjk_pkg::S_LC2) && last;
        set_s3    = (r_state == gjk_pkg::S_RD4) && last;
        set_s4    = (r_state == gjk_pkg::S_TD) && last && !pos && (r_face == 2'd2);
        remap     = (r_state == gjk_pkg::S_TD) && last && pos;
        wb_fire   = (r_state == gjk_pkg::S_WB) && (!r_o_valid || i_ready);
    end

    // next state and step counter
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gjk_pkg::S_IDLE: begin
                if (i_valid) begin
                    priority if (i_start_req || (r_size == '0)) n_state = gjk_pkg::S_WB;
                    else if (r_fin != gjk_pkg::ST_CONT)         n_state = gjk_pkg::S_WB;
                    else                                        n_state = gjk_pkg::S_DOTP;
                end
            end
            gjk_pkg::S_DOTP: begin
                if (last) begin
                    priority if (!pos)              n_state = gjk_pkg::S_WB;
                    else if (r_size == CNT_W'(1))   n_state = gjk_pkg::S_LD;
                    else if (r_size == CNT_W'(2))   n_state = gjk_pkg::S_RN;
                    else                            n_state = gjk_pkg::S_TC;
                end
            end
            gjk_pkg::S_LD:  if (last) n_state = pos ? gjk_pkg::S_LC1 : gjk_pkg::S_WB;
            gjk_pkg::S_LC1: if (last) n_state = gjk_pkg::S_LC2;
            gjk_pkg::S_LC2: if (last) n_state = gjk_pkg::S_WB;
            gjk_pkg::S_RN:  if (last) n_state = gjk_pkg::S_RT;
            gjk_pkg::S_RT:  if (last) n_state = gjk_pkg::S_RD1;
            gjk_pkg::S_RD1: if (last) n_state = pos ? gjk_pkg::S_RD2 : gjk_pkg::S_RU;
            gjk_pkg::S_RD2: if (last) n_state = pos ? gjk_pkg::S_LC1 : gjk_pkg::S_LD;
            gjk_pkg::S_RU:  if (last) n_state = gjk_pkg::S_RD3;
            gjk_pkg::S_RD3: if (last) n_state = pos ? gjk_pkg::S_LD : gjk_pkg::S_RD4;
            gjk_pkg::S_RD4: if (last) n_state = gjk_pkg::S_WB;
            gjk_pkg::S_TC:  if (last) n_state = gjk_pkg::S_TD;
            gjk_pkg::S_TD: begin
                if (last) begin
                    priority if (pos)            n_state = gjk_pkg::S_RN;
                    else if (r_face == 2'd2)     n_state = gjk_pkg::S_WB;
                    else                         n_state = gjk_pkg::S_TC;
                end
            end
            gjk_pkg::S_WB:  if (wb_fire) n_state = gjk_pkg::S_IDLE;
            default:        n_state = gjk_pkg::S_IDLE;
        endcase
        if ((n_state != r_state) || (r_state == gjk_pkg::S_IDLE) ||
            (r_state == gjk_pkg::S_WB)) begin
            n_k = '0;
        end else begin
            n_k = r_k + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gjk_pkg::S_IDLE;
            r_k       <= '0;
            r_size    <= '0;
            r_fin     <= gjk_pkg::ST_CONT;
            r_lsel    <= 1'b0;
            r_face    <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            // simplex size and status
            priority if (set_start)   r_size <= CNT_W'(1);
            else if (set_s1)          r_size <= CNT_W'(1);
            else if (set_s2)          r_size <= CNT_W'(2);
            else if (set_s3)          r_size <= CNT_W'(3);
            else if (set_s4)          r_size <= CNT_W'(4);
            priority if (set_start)   r_fin <= gjk_pkg::ST_CONT;
            else if (set_sep)         r_fin <= gjk_pkg::ST_SEP;
            else if (set_s4)          r_fin <= gjk_pkg::ST_HIT;
            // line operand select
            if ((r_state == gjk_pkg::S_LD) && last)  r_lsel <= 1'b0;
            if ((r_state == gjk_pkg::S_RD2) && last) r_lsel <= 1'b1;
            // tetra face walk
            if ((r_state == gjk_pkg::S_DOTP) && last) r_face <= 2'd0;
            if ((r_state == gjk_pkg::S_TD) && last && !pos) r_face <= r_face + 2'd1;
            // output beat
            if (wb_fire)       r_o_valid <= 1'b1;
            else if (i_ready)  r_o_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // load working points on accept
        if (accept) begin
            r_a <= p_in;
            r_b <= r_s0;
            r_c <= r_s1;
            r_d <= r_s2;
        end
        // shared multiplier, then accumulate
        r_prod <= w_sel * s_sel;
        if (r_k != '0) r_acc <= acc_n;
        // store a finished cross product component
        if (is_cross && (r_k != '0) && j[0]) begin
            unique case (r_state)
                gjk_pkg::S_RN:  r_n[j[2:1]]   <= acc_n[N_W-1:0];
                gjk_pkg::S_LC2: r_dir[j[2:1]] <= acc_n[WD_W-1:0];
                default:        r_t[j[2:1]]   <= acc_n[WD_W-1:0];
            endcase
        end
        // reorder points for the chosen tetra face
        if (remap) begin
            if (r_face == 2'd1) begin
                r_b <= r_c;
                r_c <= r_d;
            end else if (r_face == 2'd2) begin
                r_b <= r_d;
                r_c <= r_b;
            end
        end
        // commit the reduced simplex
        if (set_start) begin
            r_s0 <= p_in;
            for (int i = 0; i < 3; i++) r_dir[i] <= -WD_W'(p_in[i]);
        end
        if (set_s1) begin
            r_s0 <= r_a;
            r_s1 <= r_a;
            r_s2 <= r_a;
            for (int i = 0; i < 3; i++) r_dir[i] <= WD_W'(ao[i]);
        end
        if (set_s2) begin
            r_s0 <= r_a;
            r_s1 <= r_lsel ? r_c : r_b;
            r_s2 <= r_lsel ? r_c : r_b;
        end
        if (set_s3) begin
            r_s0 <= r_a;
            r_s1 <= pos ? r_b : r_c;
            r_s2 <= pos ? r_c : r_b;
            for (int i = 0; i < 3; i++) begin
                r_dir[i] <= pos ? WD_W'(r_n[i]) : -WD_W'(r_n[i]);
            end
        end
        if (set_s4) begin
            r_s0 <= r_a;
            r_s1 <= r_b;
            r_s2 <= r_c;
        end
        // capture the result beat
        if (wb_fire) begin
            r_o_dir  <= r_dir;
            r_o_stat <= r_fin;
            r_o_cnt  <= r_size;
        end
    end

    assign o_ready       = (r_state == gjk_pkg::S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_dir_x       = r_o_dir[0];
    assign o_dir_y       = r_o_dir[1];
    assign o_dir_z       = r_o_dir[2];
    assign o_status      = r_o_stat;
    assign o_point_count = r_o_cnt;

endmodule

@@ hdl/gjk_chk.sv @@
// ----------------------------------------------------------------------------
// gjk_chk
// Port-level checks for the GJK simplex refinement core, bound to the top.
// ----------------------------------------------------------------------------
module gjk_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic signed [gjk_pkg::WD_W-1:0] o_dir_x,
    input logic signed [gjk_pkg::WD_W-1:0] o_dir_y,
    input logic signed [gjk_pkg::WD_W-1:0] o_dir_z,
    input logic [1:0]                      o_status,
    input logic [gjk_pkg::CNT_W-1:0]       o_point_count
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dir_x) && $stable(o_dir_y) &&
        $stable(o_dir_z) && $stable(o_status) && $stable(o_point_count))
        else $error("result beat changed while stalled");

    // simplex holds one to four points
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point_count == 3'd1) || (o_point_count == 3'd2) ||
                    (o_point_count == 3'd3) || (o_point_count == 3'd4))
        else $error("point count out of range");

    // intersecting comes only with a full tetrahedron
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == gjk_pkg::ST_HIT) |-> (o_point_count == 3'd4))
        else $error("intersecting without a tetrahedron");

    // one point at a time: drop ready after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output not cleared by reset");

endmodule

bind gjk_simplex_refine_step gjk_chk u_gjk_chk (.*);

@@ test/tb_gjk_simplex_refine_step.sv @@
// ----------------------------------------------------------------------------
// tb_gjk_simplex_refine_step
// Drives support points into the GJK simplex refinement core with random idling
// on both channels and compares every result beat with an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_gjk_simplex_refine_step;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0]  t_i64;
    typedef logic signed [127:0] t_i128;

    typedef struct packed {
        logic signed [52:0] dx;
        logic signed [52:0] dy;
        logic signed [52:0] dz;
        gjk_pkg::t_status   st;
        logic [2:0]         cnt;
    } t_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: GJK predictor plus queue of expected result beats
    // ------------------------------------------------------------------------
    class gjk_scoreboard;
        t_i64             sx[4], sy[4], sz[4];
        int               npts;
        t_i64             wx, wy, wz;
        gjk_pkg::t_status fin;
        t_beat            pending[$];
        int               errors;

        function new();
            for (int i = 0; i < 4; i++) begin
                sx[i] = 0; sy[i] = 0; sz[i] = 0;
            end
            npts = 0; wx = 0; wy = 0; wz = 0; fin = gjk_pkg::ST_CONT; errors = 0;
        endfunction

        function bit positive_dot(t_i64 ax, t_i64 ay, t_i64 az,
                                  t_i64 bx, t_i64 by, t_i64 bz);
            t_i128 s;
            s = t_i128'(ax) * t_i128'(bx) + t_i128'(ay) * t_i128'(by)
              + t_i128'(az) * t_i128'(bz);
            return s > 0;
        endfunction

        function void vcross(t_i64 ax, t_i64 ay, t_i64 az, t_i64 bx, t_i64 by, t_i64 bz,
                             output t_i64 rx, output t_i64 ry, output t_i64 rz);
            rx = ay * bz - az * by;
            ry = az * bx - ax * bz;
            rz = ax * by - ay * bx;
        endfunction

        function void keep(int n, t_i64 ax, t_i64 ay, t_i64 az, t_i64 bx, t_i64 by,
                           t_i64 bz, t_i64 cx, t_i64 cy, t_i64 cz);
            sx[0] = ax; sy[0] = ay; sz[0] = az;
            sx[1] = bx; sy[1] = by; sz[1] = bz;
            sx[2] = cx; sy[2] = cy; sz[2] = cz;
            npts = n;
        endfunction

        function void reduce_line(t_i64 ax, t_i64 ay, t_i64 az,
                                  t_i64 bx, t_i64 by, t_i64 bz);
            t_i64 ex, ey, ez, tx, ty, tz;
            ex = bx - ax; ey = by - ay; ez = bz - az;
            if (positive_dot(ex, ey, ez, -ax, -ay, -az)) begin
                keep(2, ax, ay, az, bx, by, bz, bx, by, bz);
                vcross(ex, ey, ez, -ax, -ay, -az, tx, ty, tz);
                vcross(tx, ty, tz, ex, ey, ez, wx, wy, wz);
            end else begin
                keep(1, ax, ay, az, ax, ay, az, ax, ay, az);
                wx = -ax; wy = -ay; wz = -az;
            end
        endfunction

        function void reduce_triangle(t_i64 ax, t_i64 ay, t_i64 az, t_i64 bx, t_i64 by,
                                      t_i64 bz, t_i64 cx, t_i64 cy, t_i64 cz);
            t_i64 bax, bay, baz, cax, cay, caz, nx, ny, nz, tx, ty, tz;
            bax = bx - ax; bay = by - ay; baz = bz - az;
            cax = cx - ax; cay = cy - ay; caz = cz - az;
            vcross(bax, bay, baz, cax, cay, caz, nx, ny, nz);
            vcross(nx, ny, nz, cax, cay, caz, tx, ty, tz);
            if (positive_dot(tx, ty, tz, -ax, -ay, -az)) begin
                if (positive_dot(cax, cay, caz, -ax, -ay, -az)) begin
                    keep(2, ax, ay, az, cx, cy, cz, cx, cy, cz);
                    vcross(cax, cay, caz, -ax, -ay, -az, tx, ty, tz);
                    vcross(tx, ty, tz, cax, cay, caz, wx, wy, wz);
                end else begin
                    reduce_line(ax, ay, az, bx, by, bz);
                end
                return;
            end
            vcross(bax, bay, baz, nx, ny, nz, tx, ty, tz);
            if (positive_dot(tx, ty, tz, -ax, -ay, -az)) begin
                reduce_line(ax, ay, az, bx, by, bz);
            end else if (positive_dot(nx, ny, nz, -ax, -ay, -az)) begin
                keep(3, ax, ay, az, bx, by, bz, cx, cy, cz);
                wx = nx; wy = ny; wz = nz;
            end else begin
                keep(3, ax, ay, az, cx, cy, cz, bx, by, bz);
                wx = -nx; wy = -ny; wz = -nz;
            end
        endfunction

        // returns 1 when the tetrahedron holds the origin
        function bit reduce_tetra(t_i64 ax, t_i64 ay, t_i64 az, t_i64 bx, t_i64 by,
                                  t_i64 bz, t_i64 cx, t_i64 cy, t_i64 cz,
                                  t_i64 dx, t_i64 dy, t_i64 dz);
            t_i64 bax, bay, baz, cax, cay, caz, dax, day, daz, tx, ty, tz;
            bax = bx - ax; bay = by - ay; baz = bz - az;
            cax = cx - ax; cay = cy - ay; caz = cz - az;
            dax = dx - ax; day = dy - ay; daz = dz - az;
            vcross(bax, bay, baz, cax, cay, caz, tx, ty, tz);
            if (positive_dot(tx, ty, tz, -ax, -ay, -az)) begin
                reduce_triangle(ax, ay, az, bx, by, bz, cx, cy, cz);
                return 0;
            end
            vcross(cax, cay, caz, dax, day, daz, tx, ty, tz);
            if (positive_dot(tx, ty, tz, -ax, -ay, -az)) begin
                reduce_triangle(ax, ay, az, cx, cy, cz, dx, dy, dz);
                return 0;
            end
            vcross(dax, day, daz, bax, bay, baz, tx, ty, tz);
            if (positive_dot(tx, ty, tz, -ax, -ay, -az)) begin
                reduce_triangle(ax, ay, az, dx, dy, dz, bx, by, bz);
                return 0;
            end
            sx[3] = dx; sy[3] = dy; sz[3] = dz;
            keep(4, ax, ay, az, bx, by, bz, cx, cy, cz);
            return 1;
        endfunction

        // note an accepted point and queue its expected result
        function void note_point(bit start, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z);
            t_i64  px, py, pz;
            t_beat b;
            px = x; py = y; pz = z;
            if (start || npts == 0) begin
                sx[0] = px; sy[0] = py; sz[0] = pz;
                npts = 1; wx = -px; wy = -py; wz = -pz; fin = gjk_pkg::ST_CONT;
            end else if (fin == gjk_pkg::ST_CONT) begin
                if (!positive_dot(px, py, pz, wx, wy, wz))
                    fin = gjk_pkg::ST_SEP;
                else if (npts == 1)
                    reduce_line(px, py, pz, sx[0], sy[0], sz[0]);
                else if (npts == 2)
                    reduce_triangle(px, py, pz, sx[0], sy[0], sz[0], sx[1], sy[1], sz[1]);
                else if (reduce_tetra(px, py, pz, sx[0], sy[0], sz[0], sx[1], sy[1],
                                      sz[1], sx[2], sy[2], sz[2]))
                    fin = gjk_pkg::ST_HIT;
            end
            b.dx = wx[52:0]; b.dy = wy[52:0]; b.dz = wz[52:0];
            b.st = fin; b.cnt = npts[2:0];
            pending.push_back(b);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("error: %s got %0h expected %0h", what, got, want);
        endtask

        task check_result(t_beat got);
            t_beat want;
            if (pending.size() == 0) begin
                report("unexpected beat", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.dx !== want.dx) report("dir_x", got.dx, want.dx);
            if (got.dy !== want.dy) report("dir_y", got.dy, want.dy);
            if (got.dz !== want.dz) report("dir_z", got.dz, want.dz);
            if (got.st !== want.st) report("status", got.st, want.st);
            if (got.cnt !== want.cnt) report("point_count", got.cnt, want.cnt);
        endtask
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, i_start_req, o_valid, i_ready;
    logic signed [15:0] i_point_x, i_point_y, i_point_z;
    logic signed [52:0] o_dir_x, o_dir_y, o_dir_z;
    logic [1:0] o_status;
    logic [2:0] o_point_count;

    gjk_simplex_refine_step dut (.*);

    gjk_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    int  hold_cycles;
    int  cycles;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted input and result beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_point(i_start_req, i_point_x, i_point_y, i_point_z);
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_dir_x, o_dir_y, o_dir_z, gjk_pkg::t_status'(o_status),
                             o_point_count});
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 800000) begin
            $display("gjk_simplex_refine_step: mismatch");
            $finish;
        end
    end

    // send one point beat and wait for acceptance; valid drops on the next idle
    task automatic send_point(bit start, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_req <= start;
        i_point_x <= x; i_point_y <= y; i_point_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(200) - 100);
            2: return 16'($urandom_range(4000) - 2000);
            default: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
        endcase
    endfunction

    // one query: start then a run of points, most chosen toward the direction
    task automatic run_query();
        int n;
        logic signed [15:0] px, py, pz;
        send_point(1'b1, rand_coord(), rand_coord(), rand_coord());
        n = int'($urandom_range(6, 1));
        repeat (n) begin
            if ($urandom_range(9) < 8) begin
                // lean toward the current direction to get past the separation test
                px = sb.wx > 0 ? 16'($urandom_range(3000)) : 16'(-$urandom_range(3000));
                py = sb.wy > 0 ? 16'($urandom_range(3000)) : 16'(-$urandom_range(3000));
                pz = sb.wz > 0 ? 16'($urandom_range(3000)) : 16'(-$urandom_range(3000));
                if ($urandom_range(3) == 0) px = rand_coord();
            end else begin
                px = rand_coord(); py = rand_coord(); pz = rand_coord();
            end
            send_point(1'b0, px, py, pz);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n = 0; i_valid = 0; i_start_req = 0; i_ready = 0;
        i_point_x = 0; i_point_y = 0; i_point_z = 0;
        cycles = 0; hold_cycles = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no query begun, extremes, zero direction, finished repeats
        send_point(1'b0, 16'sh7fff, -16'sh8000, 16'sh0001);
        send_point(1'b0, 16'sh0010, 16'sh0000, 16'sh0000);
        send_point(1'b1, 16'sh0000, 16'sh0000, 16'sh0000);
        send_point(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(1'b0, 16'sh0005, 16'sh0005, 16'sh0005);
        // tetrahedron around the origin
        send_point(1'b1, 16'sh000a, 16'sh0000, 16'sh0000);
        send_point(1'b0, -16'sh000a, 16'sh0001, 16'sh0000);
        send_point(1'b0, 16'sh0000, 16'sh000a, 16'sh0000);
        send_point(1'b0, 16'sh0000, -16'sh0005, 16'sh000a);
        send_point(1'b0, 16'sh0000, -16'sh0005, -16'sh000a);
        send_point(1'b0, 16'sh0003, 16'sh0003, 16'sh0003);
        send_point(1'b1, -16'sh8000, -16'sh8000, -16'sh8000);
        send_point(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(1'b0, -16'sh8000, 16'sh7fff, -16'sh8000);
        send_point(1'b1, 16'shffff, 16'sh5555, 16'shaaaa);
        send_point(1'b0, 16'sh0001, -16'sh5555, 16'sh5555);

        // random with idling on both sides, then none
        send_idle_pct = 23; recv_idle_pct = 87;
        repeat (45) run_query();
        // sender pauses until every result is back
        drain();
        send_idle_pct = 87; recv_idle_pct = 23;
        repeat (45) run_query();
        send_idle_pct = 0; recv_idle_pct = 0;
        // long receiver hold-off while points keep coming
        hold_cycles <= 400;
        repeat (40) run_query();

        drain();
        if (sb.errors == 0)
            $display("gjk_simplex_refine_step: match");
        else
            $display("gjk_simplex_refine_step: mismatch");
        $finish;
    end
endmodule

@@ gjk_simplex_refine_step.f @@
hdl/gjk_pkg.sv
hdl/gjk_simplex_refine_step.sv
hdl/gjk_chk.sv
test/tb_gjk_simplex_refine_step.sv
